@@ rtl/kwbe_pkg.sv @@
`timescale 1ns / 1ps
package kwbe_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int DIV_STEPS       = 64;
  localparam int ENTRY_W         = 96;
  localparam int CFG_IDX_W       = 2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BANDWIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZER = 2'd3;

  localparam logic [10:0] ENTRIES_RST = 11'd1;
  localparam logic [31:0] ONE_Q16     = 32'h0001_0000;

  localparam logic [63:0] TWO_POW_32     = 64'h0000_0001_0000_0000;
  localparam logic [63:0] TWO_POW_16     = 64'h0000_0000_0001_0000;
  localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;
  localparam logic [63:0] EST_MAX        = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] EST_MIN        = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] m;
    logic [63:0] dv;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic        sat;
    logic [63:0] q;
  } md_rsp_t;

  typedef struct packed {
    logic        vld;
    logic [63:0] hi;
    logic [63:0] lq;
  } div_stage_t;

  function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

@@ rtl/kwbe_in_if.sv @@
`timescale 1ns / 1ps
interface kwbe_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic        [9:0]  entry_index;
  logic        [31:0] entry_distance;
  logic signed [31:0] entry_z;
  logic signed [31:0] entry_e;
  logic        [31:0] query_distance;

  modport source (output valid, command, entry_index, entry_distance, entry_z, entry_e,
                  query_distance, input ready);
  modport sink (input valid, command, entry_index, entry_distance, entry_z, entry_e,
                query_distance, output ready);
endinterface

@@ rtl/kwbe_out_if.sv @@
`timescale 1ns / 1ps
interface kwbe_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] estimate;
  logic               overflow;

  modport source (output valid, estimate, overflow, input ready);
  modport sink (input valid, estimate, overflow, output ready);
endinterface

@@ rtl/kwbe_cfg_if.sv @@
`timescale 1ns / 1ps
interface kwbe_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/kernel_weighted_band_estimate_top.sv @@
`timescale 1ns / 1ps
// Kernel weighted band estimate. A load transfer writes one table entry (distance, z, e)
// and produces no result. A query transfer scans entries 0 to n-1 and returns one signed
// Q32.32 estimate with an overflow flag. The scan skips each entry outside the band or
// with a zero weight product. Each entry in the band takes six passes through the shared
// multiply-divide unit, each made of 32 by 32 partial products, one range check and a
// 64-cell restoring divider chain that yields one quotient bit per cell. A query adds a
// setup step and the final divide by the normalizer. Saturation ends the scan early.
// The block takes a new transfer while an earlier result still waits at the output register.
module kernel_weighted_band_estimate_top import kwbe_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  kwbe_in_if.sink    in_bus,
  kwbe_out_if.source out_bus,
  kwbe_cfg_if.sink   cfg_bus
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_PRD  = 4'd4;
  localparam logic [3:0] S_TST  = 4'd5;
  localparam logic [3:0] S_MD   = 4'd6;
  localparam logic [3:0] S_MW   = 4'd7;
  localparam logic [3:0] S_TERM = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;
  localparam logic [3:0] S_FW   = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  // Per-term passes through the multiply-divide unit.
  localparam logic [2:0] ST_RATIO  = 3'd0;
  localparam logic [2:0] ST_SQUARE = 3'd1;
  localparam logic [2:0] ST_KERNEL = 3'd2;
  localparam logic [2:0] ST_TWOPI  = 3'd3;
  localparam logic [2:0] ST_BL     = 3'd4;
  localparam logic [2:0] ST_DIST   = 3'd5;

  logic [3:0]  state_r;
  logic [10:0] eiu_r;
  logic [31:0] bw_r;
  logic [31:0] lam_r;
  logic [31:0] nrm_r;
  logic [31:0] q_r;
  logic [63:0] bl_r;
  logic [CW-1:0] j_r;
  logic [CW-1:0] n_r;
  logic [63:0] sum_r;
  logic [31:0] u_r;
  logic        inb_r;
  logic        neg_r;
  logic [31:0] mz_r;
  logic [31:0] me_r;
  logic [31:0] d_r;
  logic [63:0] p_r;
  logic [63:0] t_r;
  logic [2:0]  stage_r;
  logic [63:0] res_est_r;
  logic        res_ovf_r;
  logic        out_valid_r;
  logic [63:0] out_est_r;
  logic        out_ovf_r;

  logic          in_acc;
  logic          we;
  logic [AW-1:0] waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [ENTRY_W-1:0] rdata;
  logic [31:0]   rd_d;
  logic [31:0]   rd_z;
  logic [31:0]   rd_e;
  logic [31:0]   u_abs;
  logic [CW-1:0] n_lim;
  logic [63:0]   k_diff;
  logic [63:0]   k_val;
  logic [63:0]   term;
  logic [63:0]   sum_add;
  logic          add_ovf;
  logic [63:0]   fmag;
  logic          fin_over;
  md_req_t       md_req;
  md_rsp_t       md_rsp;

  assign in_bus.ready  = (state_r == S_IDLE);
  assign cfg_bus.ready = 1'b1;
  assign in_acc        = in_bus.valid && in_bus.ready;

  assign out_bus.valid    = out_valid_r;
  assign out_bus.estimate = out_est_r;
  assign out_bus.overflow = out_ovf_r;

  // Loads beyond the table depth are dropped.
  assign we    = in_acc && (in_bus.command == CMD_LOAD) &&
                 (32'(in_bus.entry_index) < 32'(TABLE_DEPTH));
  assign waddr = AW'(in_bus.entry_index);
  assign wdata = {in_bus.entry_distance, in_bus.entry_z, in_bus.entry_e};
  assign raddr = j_r[AW-1:0];

  kwbe_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_d  = rdata[95:64];
  assign rd_z  = rdata[63:32];
  assign rd_e  = rdata[31:0];
  assign u_abs = (q_r >= rd_d) ? (q_r - rd_d) : (rd_d - q_r);
  assign n_lim = (32'(eiu_r) < 32'(TABLE_DEPTH)) ? CW'(eiu_r) : CW'(TABLE_DEPTH);

  // Kernel shape 3/4 * (1 - r^2), with r^2 from the previous pass held in t_r.
  assign k_diff = TWO_POW_32 - t_r;
  assign k_val  = ((k_diff << 1) + k_diff) >> 2;

  always_comb begin
    md_req.start = (state_r == S_MD) || (state_r == S_FIN);
    md_req.a     = t_r;
    md_req.m     = TWO_POW_32;
    md_req.dv    = TWO_POW_32;
    if (state_r == S_FIN) begin
      md_req.a  = fmag;
      md_req.m  = TWO_POW_16;
      md_req.dv = {32'd0, nrm_r};
    end else begin
      unique case (stage_r)
        ST_RATIO: begin
          md_req.a  = {32'd0, u_r};
          md_req.dv = {32'd0, bw_r};
        end
        ST_SQUARE: md_req.m = t_r;
        ST_KERNEL: begin
          md_req.a = p_r;
          md_req.m = k_val;
        end
        ST_TWOPI:  md_req.m = INV_TWO_PI_Q32;
        ST_BL:     md_req.dv = bl_r;
        ST_DIST: begin
          md_req.m  = TWO_POW_16;
          md_req.dv = {32'd0, d_r};
        end
        default: md_req.a = t_r;
      endcase
    end
  end

  kwbe_muldiv u_md (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (md_req),
    .rsp  (md_rsp)
  );

  // Signed accumulation; overflow when both addends share a sign that the sum loses.
  assign term     = neg_r ? (64'd0 - t_r) : t_r;
  assign sum_add  = sum_r + term;
  assign add_ovf  = (sum_r[63] == term[63]) && (sum_add[63] != sum_r[63]);
  assign fmag     = sum_r[63] ? (64'd0 - sum_r) : sum_r;
  assign fin_over = sum_r[63] ? (md_rsp.q > EST_MIN) : md_rsp.q[63];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      eiu_r       <= ENTRIES_RST;
      bw_r        <= ONE_Q16;
      lam_r       <= ONE_Q16;
      nrm_r       <= ONE_Q16;
    end else begin
      if (cfg_bus.valid) begin
        unique case (cfg_bus.index)
          CFG_ENTRIES:    eiu_r <= cfg_bus.data[10:0];
          CFG_BANDWIDTH:  bw_r  <= cfg_bus.data;
          CFG_INTENSITY:  lam_r <= cfg_bus.data;
          CFG_NORMALIZER: nrm_r <= cfg_bus.data;
          default:        eiu_r <= eiu_r;
        endcase
      end

      // In S_OUT the output register is refilled below instead.
      if (out_valid_r && out_bus.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc && (in_bus.command == CMD_QUERY)) begin
            q_r     <= in_bus.query_distance;
            state_r <= S_INIT;
          end
        end
        S_INIT: begin
          bl_r  <= mul32(bw_r, lam_r);
          n_r   <= n_lim;
          j_r   <= '0;
          sum_r <= 64'd0;
          if ((lam_r == 32'd0) || (nrm_r == 32'd0)) begin
            res_est_r <= EST_MAX;
            res_ovf_r <= 1'b1;
            state_r   <= S_OUT;
          end else if (bw_r == 32'd0) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= (j_r == n_r) ? S_FIN : S_CHK;
        end
        S_CHK: begin
          u_r     <= u_abs;
          inb_r   <= (u_abs < bw_r);
          neg_r   <= rd_z[31] ^ rd_e[31];
          mz_r    <= mag32(rd_z);
          me_r    <= mag32(rd_e);
          d_r     <= (rd_d == 32'd0) ? 32'd1 : rd_d;
          state_r <= S_PRD;
        end
        S_PRD: begin
          p_r     <= mul32(mz_r, me_r);
          state_r <= S_TST;
        end
        S_TST: begin
          if (!inb_r || (p_r == 64'd0)) begin
            j_r     <= j_r + CW'(1);
            state_r <= S_RD;
          end else begin
            stage_r <= ST_RATIO;
            state_r <= S_MD;
          end
        end
        S_MD: begin
          state_r <= S_MW;
        end
        S_MW: begin
          if (md_rsp.done) begin
            t_r <= md_rsp.q;
            if (md_rsp.sat) begin
              res_est_r <= neg_r ? EST_MIN : EST_MAX;
              res_ovf_r <= 1'b1;
              state_r   <= S_OUT;
            end else if (stage_r == ST_DIST) begin
              state_r <= S_TERM;
            end else begin
              stage_r <= stage_r + 3'd1;
              state_r <= S_MD;
            end
          end
        end
        S_TERM: begin
          if (t_r[63]) begin
            res_est_r <= neg_r ? EST_MIN : EST_MAX;
            res_ovf_r <= 1'b1;
            state_r   <= S_OUT;
          end else if (add_ovf) begin
            res_est_r <= term[63] ? EST_MIN : EST_MAX;
            res_ovf_r <= 1'b1;
            state_r   <= S_OUT;
          end else begin
            sum_r   <= sum_add;
            j_r     <= j_r + CW'(1);
            state_r <= S_RD;
          end
        end
        S_FIN: begin
          state_r <= S_FW;
        end
        S_FW: begin
          if (md_rsp.done) begin
            if (md_rsp.sat || fin_over) begin
              res_est_r <= sum_r[63] ? EST_MIN : EST_MAX;
              res_ovf_r <= 1'b1;
            end else begin
              res_est_r <= sum_r[63] ? (64'd0 - md_rsp.q) : md_rsp.q;
              res_ovf_r <= 1'b0;
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_bus.ready) begin
            out_valid_r <= 1'b1;
            out_est_r   <= res_est_r;
            out_ovf_r   <= res_ovf_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The multiply-divide unit only answers while the sequencer waits for it.
  a_md_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    md_rsp.done |-> ((state_r == S_MW) || (state_r == S_FW)))
    else $error("multiply-divide result with no pass pending");

  // A flagged result carries one of the two saturation values.
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovf_r) |-> ((out_est_r == EST_MAX) || (out_est_r == EST_MIN)))
    else $error("overflow flag with an unsaturated estimate");

  // A load completes in the cycle of its transfer.
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_bus.command == CMD_LOAD)) |=> (state_r == S_IDLE))
    else $error("load transfer left the sequencer busy");
`endif
endmodule

@@ rtl/kwbe_ram.sv @@
`timescale 1ns / 1ps
module kwbe_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/kwbe_div_cell.sv @@
`timescale 1ns / 1ps
module kwbe_div_cell import kwbe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [63:0] dv,
  input  div_stage_t  stage_in,
  output div_stage_t  stage_out
);
  // One restoring step: shift one dividend bit into the remainder, emit one quotient bit.
  logic [63:0] hs;
  logic        ge;
  logic        vld_r;
  logic [63:0] hi_r;
  logic [63:0] lq_r;

  assign hs = {stage_in.hi[62:0], stage_in.lq[63]};
  assign ge = stage_in.hi[63] || (hs >= dv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= stage_in.vld;
    end
    hi_r <= ge ? (hs - dv) : hs;
    lq_r <= {stage_in.lq[62:0], ge};
  end

  assign stage_out.vld = vld_r;
  assign stage_out.hi  = hi_r;
  assign stage_out.lq  = lq_r;
endmodule

@@ rtl/kwbe_muldiv.sv @@
`timescale 1ns / 1ps
module kwbe_muldiv import kwbe_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  md_req_t req,
  output md_rsp_t rsp
);
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_CHK  = 2'd2;
  localparam logic [1:0] PH_DIV  = 2'd3;

  logic [1:0]   ph_r;
  logic [2:0]   cnt_r;
  logic [63:0]  a_r;
  logic [63:0]  m_r;
  logic [63:0]  dv_r;
  logic [63:0]  pp_r;
  logic [1:0]   pidx_r;
  logic         ppv_r;
  logic [127:0] acc_r;
  logic [6:0]   shamt;
  logic [31:0]  a_part;
  logic [31:0]  m_part;
  logic         satcond;

  div_stage_t chain [DIV_STEPS+1];

  // Partial product order: a0*m0, a0*m1, a1*m0, a1*m1.
  assign a_part = cnt_r[1] ? a_r[63:32] : a_r[31:0];
  assign m_part = cnt_r[0] ? m_r[63:32] : m_r[31:0];

  always_comb begin
    unique case (pidx_r)
      2'd0:    shamt = 7'd0;
      2'd3:    shamt = 7'd64;
      default: shamt = 7'd32;
    endcase
  end

  assign satcond = (dv_r == 64'd0) || (acc_r[127:64] >= dv_r);

  assign chain[0].vld = (ph_r == PH_CHK) && !satcond;
  assign chain[0].hi  = acc_r[127:64];
  assign chain[0].lq  = acc_r[63:0];

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
    kwbe_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .dv       (dv_r),
      .stage_in (chain[g]),
      .stage_out(chain[g+1])
    );
  end

  assign rsp.sat  = (ph_r == PH_CHK) && satcond;
  assign rsp.done = rsp.sat || ((ph_r == PH_DIV) && chain[DIV_STEPS].vld);
  assign rsp.q    = rsp.sat ? '1 : chain[DIV_STEPS].lq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_IDLE;
      cnt_r <= 3'd0;
      ppv_r <= 1'b0;
    end else begin
      unique case (ph_r)
        PH_IDLE: begin
          if (req.start) begin
            a_r   <= req.a;
            m_r   <= req.m;
            dv_r  <= req.dv;
            acc_r <= '0;
            cnt_r <= 3'd0;
            ppv_r <= 1'b0;
            ph_r  <= PH_MUL;
          end
        end
        PH_MUL: begin
          if (ppv_r) begin
            acc_r <= acc_r + ({64'd0, pp_r} << shamt);
          end
          if (cnt_r != 3'd4) begin
            pp_r   <= mul32(a_part, m_part);
            pidx_r <= cnt_r[1:0];
            ppv_r  <= 1'b1;
            cnt_r  <= cnt_r + 3'd1;
          end else begin
            ppv_r <= 1'b0;
            ph_r  <= PH_CHK;
          end
        end
        PH_CHK: begin
          ph_r <= satcond ? PH_IDLE : PH_DIV;
        end
        PH_DIV: begin
          if (chain[DIV_STEPS].vld) begin
            ph_r <= PH_IDLE;
          end
        end
        default: ph_r <= PH_IDLE;
      endcase
    end
  end
endmodule

@@ verif/kwbe_checker.sv @@
`timescale 1ns / 1ps
module kwbe_checker import kwbe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  kwbe_in_if         in_bus,
  kwbe_out_if        out_bus,
  kwbe_cfg_if        cfg_bus,
  output int         fail_count,
  output int         pending_estimates
);

  logic [31:0] dist_tbl [TABLE_DEPTH_DEF];
  logic [31:0] z_tbl [TABLE_DEPTH_DEF];
  logic [31:0] e_tbl [TABLE_DEPTH_DEF];
  logic [10:0] n_entries;
  logic [31:0] band_q16;
  logic [31:0] lambda_q16;
  logic [31:0] norm_q16;
  logic [64:0] estimate_queue [$];

  // Floor of a*m/dv with a 128-bit product; flags results that do not fit 64 bits.
  function automatic logic [63:0] scaled_div(input logic [63:0] a, input logic [63:0] m,
                                              input logic [63:0] dv, inout logic sat);
    logic [127:0] prod;
    logic [127:0] quo;
    prod = {64'd0, a} * {64'd0, m};
    if (dv == 64'd0 || prod[127:64] >= dv) begin
      sat = 1'b1;
      return '1;
    end
    quo = prod / {64'd0, dv};
    return quo[63:0];
  endfunction

  function automatic logic [64:0] predict_estimate(input logic [31:0] qd);
    logic signed [63:0] sum;
    logic [63:0] d, u, r, k, p, t, mag, res, lim, bl, sat_val;
    logic neg, s, sat;
    int n;
    sum = 0;
    sat = 1'b0;
    sat_val = EST_MAX;
    if (lambda_q16 == 0 || norm_q16 == 0) return {1'b1, EST_MAX};
    n = (n_entries < TABLE_DEPTH_DEF) ? n_entries : TABLE_DEPTH_DEF;
    bl = {32'd0, band_q16} * {32'd0, lambda_q16};
    for (int j = 0; j < n && !sat && band_q16 != 0; j++) begin
      d = {32'd0, dist_tbl[j]};
      u = ({32'd0, qd} >= d) ? {32'd0, qd} - d : d - {32'd0, qd};
      if (u >= {32'd0, band_q16}) continue;
      neg = z_tbl[j][31] ^ e_tbl[j][31];
      p = {32'd0, mag32(z_tbl[j])} * {32'd0, mag32(e_tbl[j])};
      if (p == 0) continue;
      if (d == 0) d = 64'd1;
      s = 1'b0;
      r = scaled_div(u, TWO_POW_32, {32'd0, band_q16}, s);
      k = (64'd3 * (TWO_POW_32 - scaled_div(r, r, TWO_POW_32, s))) >> 2;
      t = scaled_div(p, k, TWO_POW_32, s);
      t = scaled_div(t, INV_TWO_PI_Q32, TWO_POW_32, s);
      t = scaled_div(t, TWO_POW_32, bl, s);
      t = scaled_div(t, TWO_POW_16, d, s);
      if (s || t > EST_MAX) begin
        sat = 1'b1;
        sat_val = neg ? EST_MIN : EST_MAX;
        break;
      end
      if (!neg && sum > $signed(EST_MAX - t)) begin
        sat = 1'b1;
        sat_val = EST_MAX;
      end else if (neg && t != 0 && sum < $signed(EST_MIN + t)) begin
        sat = 1'b1;
        sat_val = EST_MIN;
      end else begin
        sum = neg ? sum - $signed(t) : sum + $signed(t);
      end
    end
    if (!sat) begin
      neg = sum < 0;
      mag = neg ? -sum : sum;
      s = 1'b0;
      res = scaled_div(mag, TWO_POW_16, {32'd0, norm_q16}, s);
      lim = neg ? EST_MIN : EST_MAX;
      if (!s && res <= lim) return {1'b0, neg ? -res : res};
      sat_val = neg ? EST_MIN : EST_MAX;
    end
    return {1'b1, sat_val};
  endfunction

  always @(posedge clk) begin
    logic [64:0] want;
    if (!rst_n) begin
      n_entries <= ENTRIES_RST;
      band_q16 <= ONE_Q16;
      lambda_q16 <= ONE_Q16;
      norm_q16 <= ONE_Q16;
      fail_count <= 0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        unique case (cfg_bus.index)
          CFG_ENTRIES: n_entries <= cfg_bus.data[10:0];
          CFG_BANDWIDTH: band_q16 <= cfg_bus.data;
          CFG_INTENSITY: lambda_q16 <= cfg_bus.data;
          CFG_NORMALIZER: norm_q16 <= cfg_bus.data;
        endcase
      end
      if (in_bus.valid && in_bus.ready) begin
        if (in_bus.command == CMD_LOAD) begin
          dist_tbl[in_bus.entry_index] = in_bus.entry_distance;
          z_tbl[in_bus.entry_index] = in_bus.entry_z;
          e_tbl[in_bus.entry_index] = in_bus.entry_e;
        end else begin
          estimate_queue.push_back(predict_estimate(in_bus.query_distance));
        end
      end
      if (out_bus.valid && out_bus.ready) begin
        if (estimate_queue.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected estimate %h overflow %b", out_bus.estimate, out_bus.overflow);
          fail_count <= fail_count + 1;
        end else begin
          want = estimate_queue.pop_front();
          if (want[63:0] !== out_bus.estimate || want[64] !== out_bus.overflow) begin
            if (fail_count < 10)
              $display("estimate mismatch: expected %h/%b actual %h/%b",
                       want[63:0], want[64], out_bus.estimate, out_bus.overflow);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_estimates <= estimate_queue.size();
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import kwbe_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_estimates;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_off_cycles;
  int   quiet_cycles;
  int   loaded_depth;
  logic timed_out;

  kwbe_in_if  in_bus();
  kwbe_out_if out_bus();
  kwbe_cfg_if cfg_bus();

  kernel_weighted_band_estimate_top u_top (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus), .cfg_bus(cfg_bus)
  );

  kwbe_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus), .cfg_bus(cfg_bus),
    .fail_count(fail_count), .pending_estimates(pending_estimates)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The receiver stalls at random at the current rate. A nonzero hold-off keeps ready
  // low for that many cycles, counted here, so the block fills up and stalls its input.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      out_bus.ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: a clean run never sits this long without a transfer. The bound covers the
  // slowest query, which scans up to sixteen entries in band, plus the longest receiver hold-off.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 400000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offers one item and waits for its transfer; valid stays high across back-to-back items.
  task automatic send_item(input logic cmd, input logic [9:0] idx, input logic [31:0] dist_val,
                           input logic [31:0] z, input logic [31:0] e,
                           input logic [31:0] qd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.command <= cmd;
    in_bus.entry_index <= idx;
    in_bus.entry_distance <= dist_val;
    in_bus.entry_z <= z;
    in_bus.entry_e <= e;
    in_bus.query_distance <= qd;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic load_entry(input logic [9:0] idx, input logic [31:0] dist_val,
                            input logic [31:0] z, input logic [31:0] e);
    send_item(CMD_LOAD, idx, dist_val, z, e, $urandom);
  endtask

  task automatic query_at(input logic [31:0] qd);
    send_item(CMD_QUERY, 10'($urandom), $urandom, $urandom, $urandom, qd);
  endtask

  // Lets the block drain so registers are written only while it is idle. The first cycle
  // lets the count of pending estimates see the last transfer; a trailing load yields no
  // result, so a few extra cycles cover any scan still in flight.
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_estimates != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  task automatic set_regs(input logic [10:0] n, input logic [31:0] b,
                          input logic [31:0] lam, input logic [31:0] nrm);
    drain();
    write_reg(CFG_ENTRIES, {21'd0, n});
    write_reg(CFG_BANDWIDTH, b);
    write_reg(CFG_INTENSITY, lam);
    write_reg(CFG_NORMALIZER, nrm);
    cfg_bus.valid <= 1'b0;
  endtask

  // Random content for a weight, often small so terms do not always saturate.
  function automatic logic [31:0] rand_weight();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  // One random phase: mostly queries near the loaded distances, some reloads of entries
  // already in use so that no unwritten entry is ever read.
  task automatic random_phase(input int items);
    logic [31:0] base;
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(99) < 30) begin
        int slot;
        slot = $urandom_range(loaded_depth - 1);
        load_entry(10'(slot), $urandom_range(1) ? $urandom : (slot + 1) << 16,
                   rand_weight(), rand_weight());
      end else if ($urandom_range(9) == 0) begin
        query_at($urandom);
      end else begin
        base = ($urandom_range(loaded_depth) + 1) << 16;
        query_at(base + $urandom_range(32'h0003_0000) - 32'h0001_8000);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    quiet_cycles = 0;
    loaded_depth = 8;
    in_bus.valid = 1'b0;
    in_bus.command = CMD_LOAD;
    in_bus.entry_index = '0;
    in_bus.entry_distance = '0;
    in_bus.entry_z = '0;
    in_bus.entry_e = '0;
    in_bus.query_distance = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_ENTRIES;
    cfg_bus.data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Entry 0 with reset settings, then extreme fields and weights.
    load_entry(0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    query_at(32'h0001_0000);
    query_at(32'h0000_0000);
    query_at(32'hFFFF_FFFF);
    load_entry(0, 32'h0000_0000, 32'h0002_0000, 32'hFFFF_0000);
    query_at(32'h0000_8000);
    load_entry(1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    load_entry(2, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
    load_entry(3, 32'h0003_0000, 32'h0000_0000, 32'h1234_5678);
    load_entry(1023, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    for (int i = 4; i < 8; i++) load_entry(i, (i + 1) << 16, 32'h0001_8000, 32'hFFFE_0000);
    // The first sixteen entries are written so that the random phases read loaded slots only.
    for (int i = 8; i < 16; i++) load_entry(i, (i + 1) << 16, 32'h0000_0001, 32'h0000_0001);
    // Entries in use at zero; then large bandwidth with tiny divisors to force saturation.
    set_regs(11'd0, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001);
    query_at(32'h0001_0000);
    set_regs(11'd8, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001);
    query_at(32'hFFFF_FFFF);
    query_at(32'h0000_0000);
    // Zero bandwidth, then zero intensity and zero normalizer.
    set_regs(11'd8, 32'h0000_0000, ONE_Q16, ONE_Q16);
    query_at(32'h0004_0000);
    set_regs(11'd8, 32'h0002_0000, 32'h0000_0000, ONE_Q16);
    query_at(32'h0004_0000);
    set_regs(11'd8, 32'h0002_0000, ONE_Q16, 32'h0000_0000);
    query_at(32'h0004_0000);

    // Random phases with the different idling mixes and register settings.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      loaded_depth = 4 + $urandom_range(12);
      set_regs(11'(loaded_depth), 32'h0000_4000 << $urandom_range(4), $urandom_range(1) ?
               ONE_Q16 : $urandom, $urandom_range(1) ? ONE_Q16 : $urandom_range(32'h000F_FFFF));
      if (ph == 2) hold_off_cycles <= 3000;
      random_phase(69);
      if (ph == 5) drain();
    end

    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_estimates == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
